[sv/cca_pkg.sv]
`default_nettype none

package cca_pkg;

   // Fixed widths of the row channels and the configuration port
   localparam int unsigned ROW_BITS      = 64;
   localparam int unsigned WIDTH_BITS    = 7;
   localparam int unsigned PASSES_BITS   = 3;
   localparam int unsigned THRESH_BITS   = 4;
   localparam int unsigned CSR_DATA_BITS = 7;

   // Parameter defaults
   localparam int unsigned MAX_WIDTH_DEF = 64;
   localparam int unsigned PASSES_DEF    = 4;

   // Register reset values
   localparam logic [WIDTH_BITS-1:0]  ROW_WIDTH_RST   = 7'd64;
   localparam logic [PASSES_BITS-1:0] PASSES_USED_RST = 3'd4;
   localparam logic [THRESH_BITS-1:0] SURVIVE_MIN_RST = 4'd4;
   localparam logic [THRESH_BITS-1:0] BIRTH_MIN_RST   = 4'd5;

   typedef enum logic [1:0] {
      CSR_ROW_WIDTH   = 2'd0,
      CSR_PASSES_USED = 2'd1,
      CSR_SURVIVE_MIN = 2'd2,
      CSR_BIRTH_MIN   = 2'd3
   } csr_index_type;

   // Rule settings shared by every cell; width is already clamped to MAX_WIDTH
   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [THRESH_BITS-1:0] survive_min;
      logic [THRESH_BITS-1:0] birth_min;
   } cfg_type;

endpackage

`default_nettype wire

[sv/cca_req_if.sv]
`default_nettype none

interface cca_req_if;
   logic                         valid;
   logic                         ready;
   logic [cca_pkg::ROW_BITS-1:0] cells_in;
   logic                         frame_end_in;

   modport source (output valid, output cells_in, output frame_end_in, input ready);
   modport sink (input valid, input cells_in, input frame_end_in, output ready);
endinterface

`default_nettype wire

[sv/cca_rsp_if.sv]
`default_nettype none

interface cca_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cca_pkg::ROW_BITS-1:0] cells_out;
   logic                         frame_end_out;

   modport source (output valid, output cells_out, output frame_end_out, input ready);
   modport sink (input valid, input cells_out, input frame_end_out, output ready);
endinterface

`default_nettype wire

[sv/cca_cell.sv]
`default_nettype none

module cca_cell #(
   parameter int unsigned MAX_WIDTH = cca_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cca_pkg::cfg_type     cfg,
   input  wire logic                 enable,
   input  wire logic                 step,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [MAX_WIDTH-1:0] in_row,
   input  wire logic                 in_end,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [MAX_WIDTH-1:0]      out_row,
   output logic                      out_end
);
   import cca_pkg::*;

   typedef enum logic [2:0] {
      SEEN_EMPTY = 3'b001,
      SEEN_TOP   = 3'b010,
      SEEN_BOTH  = 3'b100
   } seen_type;

   seen_type             seen_ff, seen_in;
   logic [MAX_WIDTH-1:0] top_ff, top_in;
   logic [MAX_WIDTH-1:0] cur_ff, cur_in;
   logic                 out_valid_ff, out_valid_in;
   logic [MAX_WIDTH-1:0] out_row_ff, out_row_in;
   logic                 out_end_ff, out_end_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [MAX_WIDTH-1:0] pend_row_ff, pend_row_in;
   logic [MAX_WIDTH-1:0] smooth_row;
   logic [MAX_WIDTH-1:0] width_mask;
   logic [THRESH_BITS-1:0] n;
   logic                 in_fire;
   logic                 out_fire;

   // One pass of the rule over the middle row, all columns in parallel
   always_comb begin
      n = '0;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         width_mask[c] = (c < int'(cfg.width));
      end
      smooth_row = cur_ff;
      for (int c = 1; c + 1 < MAX_WIDTH; c++) begin
         if (c + 1 < int'(cfg.width)) begin
            n = THRESH_BITS'(top_ff[c-1]) + THRESH_BITS'(top_ff[c])
              + THRESH_BITS'(top_ff[c+1]) + THRESH_BITS'(cur_ff[c-1])
              + THRESH_BITS'(cur_ff[c+1]) + THRESH_BITS'(in_row[c-1])
              + THRESH_BITS'(in_row[c]) + THRESH_BITS'(in_row[c+1]);
            if (cur_ff[c]) begin
               if (n < cfg.survive_min) smooth_row[c] = 1'b0;
            end else begin
               if (n >= cfg.birth_min) smooth_row[c] = 1'b1;
            end
         end
      end
      smooth_row = smooth_row & width_mask;
   end

   assign out_fire = out_valid_ff && out_ready;
   // A second beat of a frame end waits in the pending slot and holds off input
   assign in_ready = !pend_valid_ff && (!out_valid_ff || out_ready);
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      seen_in       = seen_ff;
      top_in        = top_ff;
      cur_in        = cur_ff;
      out_valid_in  = out_valid_ff;
      out_row_in    = out_row_ff;
      out_end_in    = out_end_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;

      if (out_fire) begin
         out_valid_in  = pend_valid_ff;
         out_row_in    = pend_row_ff;
         out_end_in    = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (in_fire) begin
         pend_valid_in = 1'b0;
         pend_row_in   = in_row;
         if (!enable) begin
            out_valid_in = 1'b1;
            out_row_in   = in_row;
            out_end_in   = in_end;
         end else begin
            case (seen_ff)
               SEEN_EMPTY: begin
                  if (in_end) begin
                     out_valid_in = 1'b1;
                     out_row_in   = in_row;
                     out_end_in   = 1'b1;
                  end else begin
                     out_valid_in = 1'b0;
                     top_in       = in_row;
                     seen_in      = SEEN_TOP;
                  end
               end
               SEEN_TOP: begin
                  out_valid_in = 1'b1;
                  out_row_in   = top_ff;
                  out_end_in   = 1'b0;
                  if (in_end) begin
                     pend_valid_in = 1'b1;
                     seen_in       = SEEN_EMPTY;
                  end else begin
                     cur_in  = in_row;
                     seen_in = SEEN_BOTH;
                  end
               end
               SEEN_BOTH: begin
                  out_valid_in = 1'b1;
                  out_row_in   = smooth_row;
                  out_end_in   = 1'b0;
                  if (in_end) begin
                     pend_valid_in = 1'b1;
                     seen_in       = SEEN_EMPTY;
                  end else begin
                     top_in = cur_ff;
                     cur_in = in_row;
                  end
               end
               default: begin
                  out_valid_in = 1'b0;
                  seen_in      = SEEN_EMPTY;
               end
            endcase
         end
      end

      // Drop any partial frame on every input beat of the block while bypassed
      if (!enable && step) seen_in = SEEN_EMPTY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= SEEN_EMPTY;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         seen_ff       <= seen_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      cur_ff      <= cur_in;
      out_row_ff  <= out_row_in;
      out_end_ff  <= out_end_in;
      pend_row_ff <= pend_row_in;
   end

   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;
   assign out_end   = out_end_ff;

endmodule

`default_nettype wire

[sv/cave_cellular_automaton.sv]
`default_nettype none

// Cave smoothing by the 4-5 cellular automaton rule, one grid row per beat.
// Rows enter on req_chan (bit set = wall) and pass through a chain of PASSES
// cells; each enabled cell applies one smoothing pass, holding the row above
// and the row being worked on, and releases a row once the row below it has
// arrived. Border rows and columns pass unchanged; bits at or above the
// configured width are zero on output. Cells beyond passes_used are bypassed
// as a single register each. A row is taken every cycle unless output stalls
// or a frame-end beat is pending; a frame-end row makes each enabled cell that
// holds rows send two beats, the second waiting in its pending slot and holding
// off input. Each cell has one output register; each enabled cell holds a row.
// Write the csr_ registers only while no rows are in flight.
module cave_cellular_automaton #(
   parameter int unsigned MAX_WIDTH = cca_pkg::MAX_WIDTH_DEF,
   parameter int unsigned PASSES    = cca_pkg::PASSES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   cca_req_if.sink                                   req_chan,
   cca_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_wr_en,
   input  wire cca_pkg::csr_index_type               csr_index,
   input  wire logic [cca_pkg::CSR_DATA_BITS-1:0]    csr_wr_data
);
   import cca_pkg::*;

   logic [WIDTH_BITS-1:0]  row_width_ff;
   logic [PASSES_BITS-1:0] passes_used_ff;
   logic [THRESH_BITS-1:0] survive_min_ff;
   logic [THRESH_BITS-1:0] birth_min_ff;
   logic [WIDTH_BITS-1:0]  width_eff;
   logic [MAX_WIDTH-1:0]   in_mask;
   cfg_type                cfg;
   logic                   step;
   logic [PASSES-1:0]      enable;

   logic                 ch_valid [PASSES+1];
   logic                 ch_ready [PASSES+1];
   logic [MAX_WIDTH-1:0] ch_row   [PASSES+1];
   logic                 ch_end   [PASSES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RST;
         passes_used_ff <= PASSES_USED_RST;
         survive_min_ff <= SURVIVE_MIN_RST;
         birth_min_ff   <= BIRTH_MIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_WIDTH:   row_width_ff   <= csr_wr_data[WIDTH_BITS-1:0];
            CSR_PASSES_USED: passes_used_ff <= csr_wr_data[PASSES_BITS-1:0];
            CSR_SURVIVE_MIN: survive_min_ff <= csr_wr_data[THRESH_BITS-1:0];
            CSR_BIRTH_MIN:   birth_min_ff   <= csr_wr_data[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign width_eff = (row_width_ff > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
                                                              : row_width_ff;

   always_comb begin
      for (int c = 0; c < MAX_WIDTH; c++) begin
         in_mask[c] = (c < int'(width_eff));
      end
   end

   assign cfg.width       = width_eff;
   assign cfg.survive_min = survive_min_ff;
   assign cfg.birth_min   = birth_min_ff;

   assign step = req_chan.valid && req_chan.ready;

   assign ch_valid[0]    = req_chan.valid;
   assign req_chan.ready = ch_ready[0];
   assign ch_row[0]      = req_chan.cells_in[MAX_WIDTH-1:0] & in_mask;
   assign ch_end[0]      = req_chan.frame_end_in;

   for (genvar s = 0; s < PASSES; s++) begin : g_cell
      // Cells past passes_used are bypassed
      assign enable[s] = (int'(passes_used_ff) > s);

      cca_cell #(
         .MAX_WIDTH (MAX_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg),
         .enable    (enable[s]),
         .step      (step),
         .in_valid  (ch_valid[s]),
         .in_ready  (ch_ready[s]),
         .in_row    (ch_row[s]),
         .in_end    (ch_end[s]),
         .out_valid (ch_valid[s+1]),
         .out_ready (ch_ready[s+1]),
         .out_row   (ch_row[s+1]),
         .out_end   (ch_end[s+1])
      );
   end

   assign rsp_chan.valid         = ch_valid[PASSES];
   assign ch_ready[PASSES]       = rsp_chan.ready;
   assign rsp_chan.cells_out     = ROW_BITS'(ch_row[PASSES]);
   assign rsp_chan.frame_end_out = ch_end[PASSES];

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
   import cca_pkg::*;

   localparam int NSTAGES       = PASSES_DEF;
   localparam int MAXW          = MAX_WIDTH_DEF;
   localparam int SETTLE_CYCLES = 4 * NSTAGES + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [ROW_BITS-1:0] cells;
      logic                frame_end;
   } row_beat_type;

   typedef struct {
      logic [ROW_BITS-1:0] cells;
      logic                frame_end;
      logic                typed;
      logic [ROW_BITS-1:0] want;
   } directed_row_type;

   typedef struct {
      logic [CSR_DATA_BITS-1:0] w;
      logic [CSR_DATA_BITS-1:0] p;
      logic [CSR_DATA_BITS-1:0] s;
      logic [CSR_DATA_BITS-1:0] b;
   } rules_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wr_data;

   cca_req_if req_chan ();
   cca_rsp_if rsp_chan ();

   cave_cellular_automaton i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Rule settings and stage contents as the block should hold them
   logic [WIDTH_BITS-1:0]  cfg_width;
   logic [PASSES_BITS-1:0] cfg_passes;
   logic [THRESH_BITS-1:0] cfg_survive;
   logic [THRESH_BITS-1:0] cfg_birth;
   logic [ROW_BITS-1:0]    row_above [NSTAGES];
   logic [ROW_BITS-1:0]    row_mid [NSTAGES];
   int                     rows_seen [NSTAGES];

   row_beat_type rows_due [$];
   int           mismatches;
   int           stalled_cycles;
   bit           steady;
   bit           hold_rsp_req;

   directed_row_type directed_rows [20] = '{
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
      '{64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0, 64'h0},
      '{64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A},
      '{64'h0000_0000_0000_0007, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0005, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0007, 1'b1, 1'b1, 64'h0000_0000_0000_0007},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0001_0000_0000, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0010_0000, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFEF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF}
   };

   rules_type fixed_rules [12] = '{
      '{7'd64,  7'd4, 7'd4,  7'd5},
      '{7'd3,   7'd4, 7'd4,  7'd5},
      '{7'd0,   7'd2, 7'd4,  7'd5},
      '{7'd1,   7'd3, 7'd3,  7'd3},
      '{7'd2,   7'd1, 7'd4,  7'd5},
      '{7'd127, 7'd7, 7'd4,  7'd5},
      '{7'd100, 7'd4, 7'd0,  7'd0},
      '{7'd16,  7'd4, 7'd8,  7'd9},
      '{7'd40,  7'd3, 7'd15, 7'd15},
      '{7'd64,  7'd0, 7'd4,  7'd5},
      '{7'd20,  7'd5, 7'd1,  7'd8},
      '{7'd64,  7'd1, 7'd9,  7'd0}
   };

   function automatic int eff_width();
      return (cfg_width > MAXW) ? MAXW : int'(cfg_width);
   endfunction

   function automatic logic [ROW_BITS-1:0] width_mask();
      int w;
      w = eff_width();
      if (w >= ROW_BITS) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic logic [ROW_BITS-1:0] smooth_cells(input logic [ROW_BITS-1:0] up,
                                                        input logic [ROW_BITS-1:0] mid,
                                                        input logic [ROW_BITS-1:0] dn);
      int w;
      int c;
      int n;
      logic [ROW_BITS-1:0] res;
      w = eff_width();
      res = mid;
      for (c = 1; c + 1 < w; c++) begin
         n = int'(up[c-1]) + int'(up[c]) + int'(up[c+1]) + int'(mid[c-1]) + int'(mid[c+1])
           + int'(dn[c-1]) + int'(dn[c]) + int'(dn[c+1]);
         if (mid[c]) begin
            if (n < int'(cfg_survive)) res[c] = 1'b0;
         end else if (n >= int'(cfg_birth)) begin
            res[c] = 1'b1;
         end
      end
      return res & width_mask();
   endfunction

   // Run one accepted row through the enabled stages and queue the rows that fall out
   function automatic void advance_stages(input logic [ROW_BITS-1:0] cells,
                                          input logic last_row);
      row_beat_type wave [$];
      row_beat_type spill [$];
      row_beat_type b;
      int used;
      int s;
      int k;
      used = (int'(cfg_passes) > NSTAGES) ? NSTAGES : int'(cfg_passes);
      wave.push_back(row_beat_type'{cells: cells & width_mask(), frame_end: last_row});
      for (s = 0; s < NSTAGES; s++) begin
         if (s >= used) begin
            // bypassed stage drops whatever partial frame it held
            rows_seen[s] = 0;
         end else begin
            spill.delete();
            for (k = 0; k < wave.size(); k++) begin
               b = wave[k];
               case (rows_seen[s])
                  0: begin
                     if (b.frame_end) begin
                        spill.push_back(b);
                     end else begin
                        row_above[s] = b.cells;
                        rows_seen[s] = 1;
                     end
                  end
                  1: begin
                     spill.push_back(row_beat_type'{cells: row_above[s], frame_end: 1'b0});
                     if (b.frame_end) begin
                        spill.push_back(b);
                        rows_seen[s] = 0;
                     end else begin
                        row_mid[s] = b.cells;
                        rows_seen[s] = 2;
                     end
                  end
                  default: begin
                     spill.push_back(row_beat_type'{
                        cells: smooth_cells(row_above[s], row_mid[s], b.cells),
                        frame_end: 1'b0});
                     if (b.frame_end) begin
                        spill.push_back(b);
                        rows_seen[s] = 0;
                     end else begin
                        row_above[s] = row_mid[s];
                        row_mid[s] = b.cells;
                     end
                  end
               endcase
            end
            wave = spill;
         end
      end
      for (k = 0; k < wave.size(); k++) rows_due.push_back(wave[k]);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [ROW_BITS-1:0] random_cells();
      int r;
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      r = $urandom_range(0, 9);
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      if (r < 4) return a;
      if (r < 6) return a & b;
      if (r < 8) return a | b;
      return r[0] ? '1 : a & b & {$urandom, $urandom};
   endfunction

   task automatic flag_mismatch(input string what, input logic [ROW_BITS-1:0] exp_val,
                                input logic [ROW_BITS-1:0] got_val);
      if (mismatches < 40)
         $display("MISMATCH %s: expected %h, got %h at %0t", what, exp_val, got_val, $time);
      mismatches++;
   endtask

   // Entered and left just after a falling edge
   task automatic push_row(input logic [ROW_BITS-1:0] cells, input logic last_row);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cells_in     <= cells;
      req_chan.frame_end_in <= last_row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_stages(cells, last_row);
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (rows_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      case (idx)
         CSR_ROW_WIDTH:   cfg_width   = val[WIDTH_BITS-1:0];
         CSR_PASSES_USED: cfg_passes  = val[PASSES_BITS-1:0];
         CSR_SURVIVE_MIN: cfg_survive = val[THRESH_BITS-1:0];
         CSR_BIRTH_MIN:   cfg_birth   = val[THRESH_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_rules(input rules_type r);
      write_reg(CSR_ROW_WIDTH, r.w);
      write_reg(CSR_PASSES_USED, r.p);
      write_reg(CSR_SURVIVE_MIN, r.s);
      write_reg(CSR_BIRTH_MIN, r.b);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_frames(input int n);
      int sent;
      int height;
      int r;
      int k;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(0, 99);
         // mostly real grids, with one- and two-row grids mixed in
         if (r < 10) height = 1;
         else if (r < 20) height = 2;
         else height = $urandom_range(3, 10);
         for (k = 0; k < height; k++) push_row(random_cells(), k == height - 1);
         sent += height;
      end
   endtask

   // Result side: ready runs and stalls, plus one long hold on request
   initial begin
      int run;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (steady) begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end else begin
            run = pick_gap();
            if (run == 0) begin
               rsp_chan.ready <= 1'b1;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end else begin
               rsp_chan.ready <= 1'b0;
               repeat (run) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      row_beat_type exp_beat;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rows_due.size() == 0) begin
            flag_mismatch("row with nothing pending", '0, rsp_chan.cells_out);
         end else begin
            exp_beat = rows_due.pop_front();
            if (rsp_chan.cells_out !== exp_beat.cells)
               flag_mismatch("cells_out", exp_beat.cells, rsp_chan.cells_out);
            if (rsp_chan.frame_end_out !== exp_beat.frame_end)
               flag_mismatch("frame_end_out", 64'(exp_beat.frame_end),
                             64'(rsp_chan.frame_end_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      rules_type r;
      row_beat_type b;
      int i;
      int k;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.cells_in     = '0;
      req_chan.frame_end_in = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_ROW_WIDTH;
      csr_wr_data           = '0;
      mismatches            = 0;
      stalled_cycles        = 0;
      steady                = 1'b0;
      hold_rsp_req          = 1'b0;
      cfg_width             = ROW_WIDTH_RST;
      cfg_passes            = PASSES_USED_RST;
      cfg_survive           = SURVIVE_MIN_RST;
      cfg_birth             = BIRTH_MIN_RST;
      for (i = 0; i < NSTAGES; i++) begin
         row_above[i] = '0;
         row_mid[i]   = '0;
         rows_seen[i] = 0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset rules: a frame-end row always leaves unchanged, so its value is known
      for (i = 0; i < 20; i++) begin
         push_row(directed_rows[i].cells, directed_rows[i].frame_end);
         if (directed_rows[i].typed) begin
            b = rows_due.pop_back();
            b.cells = directed_rows[i].want;
            rows_due.push_back(b);
         end
      end
      settle();

      for (i = 0; i < 12; i++) begin
         set_rules(fixed_rules[i]);
         steady = (i % 4 == 3) || (i == 0);
         // fill the block while the result side holds off
         if (i == 0) hold_rsp_req = 1'b1;
         run_frames(i == 0 ? 40 : 21);
         settle();
      end
      steady = 1'b0;

      // Change the rules with a frame half done
      set_rules('{7'd64, 7'd4, 7'd4, 7'd5});
      for (k = 0; k < 5; k++) push_row(random_cells(), 1'b0);
      settle();
      set_rules('{7'd48, 7'd2, 7'd3, 7'd6});
      for (k = 0; k < 4; k++) push_row(random_cells(), k == 3);
      settle();

      for (i = 0; i < 6; i++) begin
         r.w = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(3, 64))
                                            : 7'($urandom_range(0, 127));
         r.p = 7'($urandom_range(0, 127));
         r.s = ($urandom_range(0, 99) < 75) ? 7'($urandom_range(0, 9))
                                            : 7'($urandom_range(0, 127));
         r.b = ($urandom_range(0, 99) < 75) ? 7'($urandom_range(0, 9))
                                            : 7'($urandom_range(0, 127));
         set_rules(r);
         steady = (i == 2);
         run_frames(21);
         settle();
      end

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
sv/cca_pkg.sv
sv/cca_req_if.sv
sv/cca_rsp_if.sv
sv/cca_cell.sv
sv/cave_cellular_automaton.sv
tb/sv/tb.sv
